// File: hw/rtl/status_led_pattern_sequencer_top_defines.svh
// Assertion macros shared by the status light sequencer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slps assertion failed");

`endif

// File: hw/rtl/slps_pkg.sv
// Types and constants of the status light sequencer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package slps_pkg;

  localparam int ColorW   = 8;
  localparam int ModeW    = 3;
  localparam int TimeW    = 32;
  localparam int HoldW    = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  typedef enum logic {
    KIND_SET   = 1'b0,
    KIND_FRAME = 1'b1
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE   = 3'd0,
    MODE_LISTEN = 3'd1,
    MODE_THINK  = 3'd2,
    MODE_TOOL   = 3'd3,
    MODE_REPLY  = 3'd4,
    MODE_ERROR  = 3'd5,
    MODE_SPEAK  = 3'd6
  } mode_e;

  localparam logic [CfgIdxW-1:0] CFG_REPLY_HOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_HOLD = 1'd1;

  localparam logic [HoldW-1:0] REPLY_HOLD_RST = 16'd900;
  localparam logic [HoldW-1:0] ERROR_HOLD_RST = 16'd2500;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    kind_e             kind;
    logic [ModeW-1:0]  new_mode;
    logic [TimeW-1:0]  now_ms;
  } item_t;

  localparam rgb_t RGB_TOOL  = '{red: 8'd48, green: 8'd22, blue: 8'd0};
  localparam rgb_t RGB_REPLY = '{red: 8'd0,  green: 8'd52, blue: 8'd8};
  localparam rgb_t RGB_ERROR = '{red: 8'd60, green: 8'd0,  blue: 8'd0};
  localparam rgb_t RGB_SPEAK = '{red: 8'd0,  green: 8'd40, blue: 8'd40};
  localparam rgb_t RGB_IDLE  = '{red: 8'd2,  green: 8'd2,  blue: 8'd2};

  // Pulse shape: level = PulseBase + tri * PulseSpan / half.
  localparam int PulseBase = 8;
  localparam int PulseSpan = 62;

endpackage

`default_nettype wire

// File: hw/rtl/slps_if.sv
// Valid/ready channel interfaces of the status light sequencer.
// Depends on slps_pkg for the field widths.
`default_nettype none

interface slps_item_if
  import slps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ModeW-1:0] new_mode;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, kind, new_mode, now_ms, input ready);
  modport sink   (input valid, kind, new_mode, now_ms, output ready);
endinterface

interface slps_rgb_if
  import slps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/status_led_pattern_sequencer_top.sv
// Status light mode sequencer: set items store a mode, frame items give one RGB color,
// or none when they end a reply or error hold. A frame item passes the input and result registers.
// Throughput: one item per cycle while the color sink keeps up; a color that waits to be
// taken holds the input register, so the input stalls once that register is also full.
// Reset (async, active low): mode idle, phase 0, stamp 0, hold times 900 and 2500 ms.
// Depends on slps_pkg, slps_if and the assertion macro header.
`default_nettype none
`include "status_led_pattern_sequencer_top_defines.svh"

module status_led_pattern_sequencer_top
  import slps_pkg::*;
#(
  parameter int PULSE_STEPS = 60
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  [CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [CfgDataW-1:0]      cfg_wdata_i,
  slps_item_if.sink                item_i,
  slps_rgb_if.source               rgb_o
);

  localparam int PhaseW    = (PULSE_STEPS > 1) ? $clog2(PULSE_STEPS) : 1;
  localparam int HalfSteps = PULSE_STEPS / 2;

  // Pulse level for each phase, built at elaboration.
  logic [ColorW-1:0] level_lut [PULSE_STEPS];

  for (genvar g = 0; g < PULSE_STEPS; g++) begin : g_lut
    localparam int Tri = (g < HalfSteps) ? g : (PULSE_STEPS - g);
    localparam int Lvl = (PulseBase + (Tri * PulseSpan) / HalfSteps) % 256;
    assign level_lut[g] = Lvl[ColorW-1:0];
  end

  // Configuration registers.
  logic [HoldW-1:0] reply_hold_q;
  logic [HoldW-1:0] error_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_hold_q <= REPLY_HOLD_RST;
      error_hold_q <= ERROR_HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPLY_HOLD: reply_hold_q <= cfg_wdata_i[HoldW-1:0];
        CFG_ERROR_HOLD: error_hold_q <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic  item_vld_q, item_vld_d;
  item_t item_q;
  logic  item_take;
  logic  adv;

  assign item_i.ready = !item_vld_q || adv;
  assign item_take    = item_i.valid && item_i.ready;
  assign item_vld_d   = item_take ? 1'b1 : (adv ? 1'b0 : item_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      item_q.kind     <= kind_e'(item_i.kind);
      item_q.new_mode <= item_i.new_mode;
      item_q.now_ms   <= item_i.now_ms;
    end
  end

  // Sequencer state.
  mode_e             mode_q, mode_d;
  logic [TimeW-1:0]  stamp_q, stamp_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] phase_nxt;
  logic [TimeW-1:0]  elapsed;
  logic              reply_expired;
  logic              error_expired;
  logic [ColorW-1:0] level;

  // Result register.
  logic out_vld_q, out_vld_d;
  rgb_t rgb_q, rgb_d;
  logic emit;

  // The item in the input register moves on when the result register is empty or being taken.
  assign adv = item_vld_q && (!out_vld_q || rgb_o.ready);

  assign phase_nxt = (phase_q == PhaseW'(PULSE_STEPS - 1)) ? '0 : phase_q + PhaseW'(1);
  assign level     = level_lut[phase_nxt];

  assign elapsed       = item_q.now_ms - stamp_q;
  assign reply_expired = elapsed > {{(TimeW-HoldW){1'b0}}, reply_hold_q};
  assign error_expired = elapsed > {{(TimeW-HoldW){1'b0}}, error_hold_q};

  always_comb begin
    mode_d  = mode_q;
    stamp_d = stamp_q;
    phase_d = phase_q;
    emit    = 1'b0;
    rgb_d   = RGB_IDLE;
    if (adv) begin
      if (item_q.kind == KIND_SET) begin
        mode_d  = mode_e'(item_q.new_mode);
        stamp_d = item_q.now_ms;
      end else begin
        emit = 1'b1;
        case (mode_q)
          MODE_LISTEN: begin
            phase_d = phase_nxt;
            rgb_d   = '{red: level, green: '0, blue: level};
          end
          MODE_THINK: begin
            phase_d = phase_nxt;
            rgb_d   = '{red: '0, green: '0, blue: level};
          end
          MODE_TOOL:  rgb_d = RGB_TOOL;
          MODE_REPLY: begin
            if (reply_expired) begin
              mode_d = MODE_IDLE;
              emit   = 1'b0;
            end
            rgb_d = RGB_REPLY;
          end
          MODE_ERROR: begin
            if (error_expired) begin
              mode_d = MODE_IDLE;
              emit   = 1'b0;
            end
            rgb_d = RGB_ERROR;
          end
          MODE_SPEAK: rgb_d = RGB_SPEAK;
          default:    rgb_d = RGB_IDLE;
        endcase
      end
    end
  end

  assign out_vld_d = adv ? emit : (out_vld_q && !rgb_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      stamp_q   <= '0;
      phase_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      stamp_q   <= stamp_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o.valid = out_vld_q;
  assign rgb_o.red   = rgb_q.red;
  assign rgb_o.green = rgb_q.green;
  assign rgb_o.blue  = rgb_q.blue;

  // A new result only ever comes from a frame item leaving the input register.
  `SLPS_ASSERT_NOW(a_result_from_frame, $rose(out_vld_q), $past(adv) && $past(item_q.kind == KIND_FRAME))
  // A set item lands in the mode and stamp registers.
  `SLPS_ASSERT_NEXT(a_set_stores, adv && item_q.kind == KIND_SET, stamp_q == $past(item_q.now_ms) && mode_q == $past(mode_e'(item_q.new_mode)))
  // The pulse phase only moves on pulse frames.
  `SLPS_ASSERT_NEXT(a_phase_hold, !(adv && item_q.kind == KIND_FRAME && (mode_q == MODE_LISTEN || mode_q == MODE_THINK)), $stable(phase_q))
  // An expired hold reverts to idle without a result.
  `SLPS_ASSERT_NEXT(a_hold_expiry, adv && item_q.kind == KIND_FRAME && ((mode_q == MODE_REPLY && reply_expired) || (mode_q == MODE_ERROR && error_expired)), mode_q == MODE_IDLE && !$rose(out_vld_q))

endmodule

`default_nettype wire

// File: bench/slps_color_checker.sv
`timescale 1ns / 100ps
// Color checker for the status light sequencer: watches the item, color and register ports,
// predicts each frame color and compares it with what the block delivers.
// Depends on slps_pkg and the channel interfaces in slps_if.
module slps_color_checker
  import slps_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_wdata_i,
  slps_item_if               item_i,
  slps_rgb_if                rgb_i,
  output int                 fails_o,
  output int                 pending_o
);

  localparam int PulseSteps = 60;
  localparam int PulseHalf  = PulseSteps / 2;
  localparam int LevelBase  = 8;
  localparam int LevelSpan  = 62;

  localparam rgb_t ToolColor  = '{red: 8'd48, green: 8'd22, blue: 8'd0};
  localparam rgb_t ReplyColor = '{red: 8'd0,  green: 8'd52, blue: 8'd8};
  localparam rgb_t ErrorColor = '{red: 8'd60, green: 8'd0,  blue: 8'd0};
  localparam rgb_t SpeakColor = '{red: 8'd0,  green: 8'd40, blue: 8'd40};
  localparam rgb_t IdleColor  = '{red: 8'd2,  green: 8'd2,  blue: 8'd2};

  logic [HoldW-1:0] reply_hold_q;
  logic [HoldW-1:0] error_hold_q;
  logic [ModeW-1:0] mode_q;
  logic [TimeW-1:0] stamp_q;
  int unsigned      phase_q;
  rgb_t             color_q[$];

  // The phase counter is shared by listening and thinking, so it only moves on pulse frames.
  function automatic logic [ColorW-1:0] next_pulse_level();
    int unsigned ramp;
    phase_q = (phase_q + 1) % PulseSteps;
    ramp = (phase_q < PulseHalf) ? phase_q : PulseSteps - phase_q;
    return ColorW'(LevelBase + ramp * LevelSpan / PulseHalf);
  endfunction

  // Returns 0 when the frame ends a reply or error hold and so gives no color.
  function automatic bit render_frame(input logic [TimeW-1:0] now, output rgb_t color);
    logic [TimeW-1:0]  elapsed;
    logic [ColorW-1:0] level;
    elapsed = now - stamp_q;
    render_frame = 1'b1;
    case (mode_q)
      MODE_LISTEN: begin
        level = next_pulse_level();
        color = '{red: level, green: 8'd0, blue: level};
      end
      MODE_THINK: begin
        level = next_pulse_level();
        color = '{red: 8'd0, green: 8'd0, blue: level};
      end
      MODE_TOOL:  color = ToolColor;
      MODE_SPEAK: color = SpeakColor;
      MODE_REPLY: begin
        if (elapsed > TimeW'(reply_hold_q)) begin
          mode_q = MODE_IDLE;
          render_frame = 1'b0;
        end else begin
          color = ReplyColor;
        end
      end
      MODE_ERROR: begin
        if (elapsed > TimeW'(error_hold_q)) begin
          mode_q = MODE_IDLE;
          render_frame = 1'b0;
        end else begin
          color = ErrorColor;
        end
      end
      default: color = IdleColor;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [ColorW-1:0] want,
                                      input logic [ColorW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rgb_t color;
    rgb_t want;
    if (!rst_ni) begin
      reply_hold_q = 16'd900;
      error_hold_q = 16'd2500;
      mode_q       = MODE_IDLE;
      stamp_q      = '0;
      phase_q      = 0;
      color_q.delete();
      fails_o      = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REPLY_HOLD: reply_hold_q = cfg_wdata_i[HoldW-1:0];
          CFG_ERROR_HOLD: error_hold_q = cfg_wdata_i[HoldW-1:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.kind == KIND_SET) begin
          mode_q  = item_i.new_mode;
          stamp_q = item_i.now_ms;
        end else if (render_frame(item_i.now_ms, color)) begin
          color_q.push_back(color);
        end
      end
      if (rgb_i.valid && rgb_i.ready) begin
        if (color_q.size() == 0) begin
          $error("color (%0d,%0d,%0d) delivered with no frame waiting",
                 rgb_i.red, rgb_i.green, rgb_i.blue);
          fails_o++;
        end else begin
          want = color_q.pop_front();
          check_field("red", want.red, rgb_i.red);
          check_field("green", want.green, rgb_i.green);
          check_field("blue", want.blue, rgb_i.blue);
        end
      end
      pending_o = color_q.size();
    end
  end

endmodule

// File: bench/tb_status_led_pattern_sequencer_top.sv
`timescale 1ns / 100ps
// Testbench top of the status light sequencer: clock, reset, item and register stimulus,
// a stalling color sink, and the verdict. Depends on slps_pkg, slps_if and slps_color_checker.
module tb_status_led_pattern_sequencer_top;
  import slps_pkg::*;

  localparam int LatencyCycles = 2;
  localparam int HoldOffCycles = 300;
  localparam int PhaseItems    = 325;
  localparam int PhaseCount    = 6;
  localparam int CycleLimit    = 400000;

  localparam logic [ModeW-1:0] ModeSpare = 3'd7;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_style_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  fails;
  int                  pending;
  int                  burst_left;
  int                  cycle_cnt;
  int                  reply_hold;
  int                  error_hold;
  bit                  squeeze_req;
  bit                  squeeze_done;

  slps_item_if item_ch ();
  slps_rgb_if  rgb_ch ();

  status_led_pattern_sequencer_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .rgb_o       (rgb_ch)
  );

  slps_color_checker color_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .rgb_i       (rgb_ch),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Items go out in bursts; while the long sink hold-off runs, the sender keeps pushing.
  task automatic push_item(input kind_e kind, input logic [ModeW-1:0] mode,
                           input logic [TimeW-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      gap = (squeeze_req && !squeeze_done) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_ch.kind     = kind;
    item_ch.new_mode = mode;
    item_ch.now_ms   = now;
    item_ch.valid    = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Set items and expiring frames give no color, so the wait runs on past the pipeline latency.
  task automatic settle();
    item_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (LatencyCycles + 2) @(negedge clk);
  endtask

  task automatic write_hold(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = CfgDataW'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin : color_sink
    sink_style_e style;
    int          style_left;
    int          period;
    int          tick;
    int          hold_cnt;
    rgb_ch.ready = 1'b0;
    style        = SINK_OPEN;
    style_left   = 0;
    period       = 3;
    tick         = 0;
    hold_cnt     = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (squeeze_req && !squeeze_done) begin
        rgb_ch.ready = 1'b0;
        hold_cnt++;
        if (hold_cnt >= HoldOffCycles) squeeze_done = 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = sink_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 120);
          period     = $urandom_range(2, 5);
        end
        style_left--;
        case (style)
          SINK_OPEN:     rgb_ch.ready = 1'b1;
          SINK_COIN:     rgb_ch.ready = 1'($urandom_range(0, 1));
          SINK_PERIODIC: rgb_ch.ready = (tick % period) != 0;
          default:       rgb_ch.ready = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status_led_pattern_sequencer_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [ModeW-1:0] mode;
    logic [TimeW-1:0] stamp;
    logic [TimeW-1:0] now;
    int               hold;
    int               frames;
    int               sent;
    item_ch.valid    = 1'b0;
    item_ch.kind     = KIND_SET;
    item_ch.new_mode = '0;
    item_ch.now_ms   = '0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    burst_left       = 0;
    squeeze_req      = 1'b0;
    squeeze_done     = 1'b0;
    reply_hold       = 900;
    error_hold       = 2500;
    rst_n            = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with the reset hold times.
    push_item(KIND_FRAME, MODE_IDLE, '0);
    push_item(KIND_SET, MODE_LISTEN, '0);
    repeat (3) push_item(KIND_FRAME, MODE_SPEAK, 32'd40);
    push_item(KIND_SET, MODE_THINK, 32'd5);
    repeat (2) push_item(KIND_FRAME, ModeSpare, 32'd80);
    push_item(KIND_SET, MODE_TOOL, 32'd100);
    push_item(KIND_FRAME, MODE_REPLY, 32'd120);
    push_item(KIND_SET, MODE_SPEAK, 32'h8000_0000);
    push_item(KIND_FRAME, MODE_ERROR, 32'h7FFF_FFFF);
    push_item(KIND_SET, ModeSpare, 32'h5555_AAAA);
    push_item(KIND_FRAME, MODE_LISTEN, 32'hAAAA_5555);
    // The reply hold spans the time wrap: elapsed equal to the hold still shows green.
    push_item(KIND_SET, MODE_REPLY, 32'hFFFF_FF00);
    push_item(KIND_FRAME, MODE_IDLE, 32'd644);
    push_item(KIND_FRAME, MODE_IDLE, 32'd645);
    push_item(KIND_FRAME, MODE_IDLE, 32'd646);
    push_item(KIND_SET, MODE_ERROR, 32'hFFFF_FFFF);
    push_item(KIND_FRAME, MODE_IDLE, 32'd2499);
    push_item(KIND_FRAME, MODE_IDLE, 32'd2500);
    push_item(KIND_FRAME, MODE_IDLE, 32'd2501);
    push_item(KIND_SET, MODE_IDLE, '1);
    push_item(KIND_FRAME, ModeSpare, 32'hFFFF_FFFF);

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      case (p)
        0: begin
          reply_hold = 0;
          error_hold = 0;
        end
        1: begin
          reply_hold = 65535;
          error_hold = 65535;
        end
        2: begin
          reply_hold = 1;
          error_hold = 2;
        end
        default: begin
          reply_hold = $urandom_range(0, 65535);
          error_hold = $urandom_range(0, 65535);
        end
      endcase
      write_hold(CFG_REPLY_HOLD, reply_hold);
      write_hold(CFG_ERROR_HOLD, error_hold);
      squeeze_req = (p == 1);

      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray item outside any well-formed sequence.
          push_item(kind_e'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom());
          sent++;
        end else begin
          case ($urandom_range(0, 3))
            0:       mode = MODE_REPLY;
            1:       mode = MODE_ERROR;
            default: mode = 3'($urandom_range(0, 7));
          endcase
          case ($urandom_range(0, 7))
            0:       stamp = '0;
            1:       stamp = '1;
            2:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            default: stamp = $urandom();
          endcase
          if (mode == MODE_REPLY) hold = reply_hold;
          else if (mode == MODE_ERROR) hold = error_hold;
          else hold = $urandom_range(0, 3000);
          if (mode == MODE_LISTEN || mode == MODE_THINK) frames = $urandom_range(1, 40);
          else frames = $urandom_range(1, 6);
          push_item(KIND_SET, mode, stamp);
          repeat (frames) begin
            // Frame times cluster around the hold boundary.
            case ($urandom_range(0, 5))
              0:       now = stamp + TimeW'(hold);
              1:       now = stamp + TimeW'(hold) + 32'd1;
              2:       now = stamp + TimeW'(hold) - 32'd1;
              3:       now = $urandom();
              default: now = stamp + TimeW'($urandom_range(0, hold));
            endcase
            push_item(KIND_FRAME, 3'($urandom_range(0, 7)), now);
          end
          sent += frames + 1;
        end
      end
    end
    settle();

    if (fails == 0 && pending == 0) begin
      $display("status_led_pattern_sequencer_top: match");
    end else begin
      $display("status_led_pattern_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
